/* src/btlpm_pkg.sv */
// Package for the binary trie longest-prefix-match block.
// Holds the controller state type, the entry source type and the opcode codes.
// No dependencies.
package btlpm_pkg;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef enum logic [1:0] {
        SRC_ROOT,
        SRC_MEM,
        SRC_FRESH
    } src_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int PLEN_W = 6;
    localparam int VISIT_W = 6;
    localparam logic [VISIT_W-1:0] VISIT_MAX = 6'd63;

endpackage

/* src/binary_trie_longest_prefix_match.sv */
// Top level of the binary trie longest-prefix-match routing table.
// Holds the node memory, the root node registers and the walk controller.
// Depends on btlpm_pkg.
//
// A beat is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high and cannot be held off. The
// walk reads one trie node from the node memory per cycle; a lookup descends
// at most ADDRESS_BITS levels below the root, and an insert at most the clamped
// prefix length, fewer when the node pool runs out on the way.
// The result strobe comes in the cycle in which busy falls, and a new beat
// may start in that same cycle. The root node lives in flip-flops, so the
// block is ready right after reset with no clearing pass.
module binary_trie_longest_prefix_match #(
    parameter int NODE_COUNT = 65536,
    parameter int ADDRESS_BITS = 32,
    parameter int PORT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [ADDRESS_BITS-1:0]       address,
    input  logic [btlpm_pkg::PLEN_W-1:0]  prefix_length,
    input  logic [PORT_BITS-1:0]          out_port,
    output logic                          done,
    output logic                          found,
    output logic [PORT_BITS-1:0]          route_port,
    output logic [btlpm_pkg::VISIT_W-1:0] nodes_visited,
    output logic                          table_full
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int NU_W = IDX_W + 1;
    localparam int LEN_W = $clog2(ADDRESS_BITS + 1);
    localparam int ENTRY_W = 1 + PORT_BITS + 2 * IDX_W;
    localparam int C0_LSB = 0;
    localparam int C1_LSB = IDX_W;
    localparam int PORT_LSB = 2 * IDX_W;
    localparam int MARK_BIT = 2 * IDX_W + PORT_BITS;
    localparam logic [NU_W-1:0] NODE_LIMIT = NU_W'(NODE_COUNT);

    logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0] rd_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    btlpm_pkg::state_t state_reg, state_next;
    btlpm_pkg::src_t   src_reg;

    logic                          op_reg;
    logic [ADDRESS_BITS-1:0]       addr_reg;
    logic [LEN_W-1:0]              levels_reg;
    logic [PORT_BITS-1:0]          port_reg;
    logic [IDX_W-1:0]              node_reg;
    logic                          found_reg;
    logic [PORT_BITS-1:0]          best_reg;
    logic [btlpm_pkg::VISIT_W-1:0] visited_reg;
    logic [NU_W-1:0]               nodes_used_reg;

    logic                 root_marked_reg;
    logic [PORT_BITS-1:0] root_port_reg;
    logic [IDX_W-1:0]     root_child0_reg;
    logic [IDX_W-1:0]     root_child1_reg;

    logic                          done_reg;
    logic                          res_found_reg;
    logic [PORT_BITS-1:0]          res_port_reg;
    logic [btlpm_pkg::VISIT_W-1:0] res_visited_reg;
    logic                          res_full_reg;

    logic                 accept;
    logic [LEN_W-1:0]     len_clamped;
    logic                 e_marked;
    logic [PORT_BITS-1:0] e_port;
    logic [IDX_W-1:0]     e_child0;
    logic [IDX_W-1:0]     e_child1;
    logic                 bit_sel;
    logic [IDX_W-1:0]     child;
    logic                 child_ok;
    logic                 at_end;
    logic                 pool_full;
    logic [IDX_W-1:0]     new_idx;
    logic                 hit_now;
    logic                 found_now;
    logic [PORT_BITS-1:0] best_now;

    logic go;
    logic alloc;
    logic mark;
    logic full_stop;
    logic finish;

    assign accept = start && (state_reg == btlpm_pkg::ST_IDLE);
    assign busy = (state_reg != btlpm_pkg::ST_IDLE);

    always_comb
    begin
        if (int'(prefix_length) > ADDRESS_BITS)
        begin
            len_clamped = LEN_W'(ADDRESS_BITS);
        end
        else
        begin
            len_clamped = LEN_W'(prefix_length);
        end
    end

    always_comb
    begin
        unique case (src_reg)
            btlpm_pkg::SRC_ROOT:
            begin
                e_marked = root_marked_reg;
                e_port   = root_port_reg;
                e_child0 = root_child0_reg;
                e_child1 = root_child1_reg;
            end
            btlpm_pkg::SRC_MEM:
            begin
                e_marked = rd_data[MARK_BIT];
                e_port   = rd_data[PORT_LSB +: PORT_BITS];
                e_child0 = rd_data[C0_LSB +: IDX_W];
                e_child1 = rd_data[C1_LSB +: IDX_W];
            end
            default:
            begin
                e_marked = 1'b0;
                e_port   = '0;
                e_child0 = '0;
                e_child1 = '0;
            end
        endcase
    end

    assign bit_sel   = addr_reg[ADDRESS_BITS-1];
    assign child     = bit_sel ? e_child1 : e_child0;
    assign child_ok  = (child != '0) && (NU_W'(child) < NODE_LIMIT);
    assign at_end    = (levels_reg == '0);
    assign pool_full = (nodes_used_reg >= NODE_LIMIT);
    assign new_idx   = nodes_used_reg[IDX_W-1:0];
    assign hit_now   = (src_reg == btlpm_pkg::SRC_MEM) && e_marked;
    assign found_now = found_reg || hit_now;
    assign best_now  = hit_now ? e_port : best_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btlpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = btlpm_pkg::ST_WALK;
                end
            end
            btlpm_pkg::ST_WALK:
            begin
                if (finish)
                begin
                    state_next = btlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btlpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        go        = 1'b0;
        alloc     = 1'b0;
        mark      = 1'b0;
        full_stop = 1'b0;
        finish    = 1'b0;
        if (state_reg == btlpm_pkg::ST_WALK)
        begin
            if (op_reg == btlpm_pkg::OP_LOOKUP)
            begin
                finish = at_end || !child_ok;
                go     = !finish;
            end
            else
            begin
                priority if (at_end)
                begin
                    mark   = 1'b1;
                    finish = 1'b1;
                end
                else if (child_ok)
                begin
                    go = 1'b1;
                end
                else if (pool_full)
                begin
                    full_stop = 1'b1;
                    finish    = 1'b1;
                end
                else
                begin
                    alloc = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        rd_en   = go;
        rd_addr = child;
        wr_addr = node_reg;
        wr_en   = (src_reg != btlpm_pkg::SRC_ROOT) &&
                  (mark || alloc || (full_stop && (src_reg == btlpm_pkg::SRC_FRESH)));
        wr_data = '0;
        wr_data[MARK_BIT]              = mark ? 1'b1 : e_marked;
        wr_data[PORT_LSB +: PORT_BITS] = mark ? port_reg : e_port;
        wr_data[C0_LSB +: IDX_W]       = (alloc && !bit_sel) ? new_idx : e_child0;
        wr_data[C1_LSB +: IDX_W]       = (alloc && bit_sel) ? new_idx : e_child1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= btlpm_pkg::ST_IDLE;
            nodes_used_reg  <= NU_W'(1);
            root_marked_reg <= 1'b0;
            root_port_reg   <= '0;
            root_child0_reg <= '0;
            root_child1_reg <= '0;
            done_reg        <= 1'b0;
            res_found_reg   <= 1'b0;
            res_port_reg    <= '0;
            res_visited_reg <= '0;
            res_full_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (alloc)
            begin
                nodes_used_reg <= nodes_used_reg + NU_W'(1);
            end
            if (src_reg == btlpm_pkg::SRC_ROOT)
            begin
                if (mark)
                begin
                    root_marked_reg <= 1'b1;
                    root_port_reg   <= port_reg;
                end
                if (alloc && !bit_sel)
                begin
                    root_child0_reg <= new_idx;
                end
                if (alloc && bit_sel)
                begin
                    root_child1_reg <= new_idx;
                end
            end
            if (finish)
            begin
                if (op_reg == btlpm_pkg::OP_LOOKUP)
                begin
                    res_found_reg   <= found_now;
                    res_port_reg    <= best_now;
                    res_visited_reg <= visited_reg;
                    res_full_reg    <= 1'b0;
                end
                else
                begin
                    res_found_reg   <= 1'b0;
                    res_port_reg    <= '0;
                    res_visited_reg <= '0;
                    res_full_reg    <= full_stop;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            addr_reg    <= address;
            levels_reg  <= (opcode == btlpm_pkg::OP_LOOKUP) ? LEN_W'(ADDRESS_BITS) : len_clamped;
            port_reg    <= out_port;
            node_reg    <= '0;
            src_reg     <= btlpm_pkg::SRC_ROOT;
            found_reg   <= root_marked_reg;
            best_reg    <= root_marked_reg ? root_port_reg : '0;
            visited_reg <= '0;
        end
        else if (state_reg == btlpm_pkg::ST_WALK)
        begin
            found_reg <= found_now;
            best_reg  <= best_now;
            if (go || alloc)
            begin
                addr_reg   <= addr_reg << 1;
                levels_reg <= levels_reg - LEN_W'(1);
                node_reg   <= go ? child : new_idx;
                src_reg    <= go ? btlpm_pkg::SRC_MEM : btlpm_pkg::SRC_FRESH;
                if (visited_reg != btlpm_pkg::VISIT_MAX)
                begin
                    visited_reg <= visited_reg + btlpm_pkg::VISIT_W'(1);
                end
            end
        end
    end

    assign done          = done_reg;
    assign found         = res_found_reg;
    assign route_port    = res_port_reg;
    assign nodes_visited = res_visited_reg;
    assign table_full    = res_full_reg;

endmodule

/* src/btlpm_checker.sv */
// Port-level checker for the binary trie longest-prefix-match block.
// Holds the checker module and the bind that attaches it to the top level.
// Depends on btlpm_pkg and binary_trie_longest_prefix_match.
module btlpm_checker #(
    parameter int PORT_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          found,
    input logic [PORT_BITS-1:0]          route_port,
    input logic [btlpm_pkg::VISIT_W-1:0] nodes_visited,
    input logic                          table_full
);

    logic in_beat;

    assign in_beat = start && !busy;

    a_beat_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("walk ended without a result strobe");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (route_port == '0))
        else $error("port reported without a match");

    a_full_is_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (!found && (nodes_visited == '0)))
        else $error("table full reported on a lookup result");

endmodule

bind binary_trie_longest_prefix_match btlpm_checker #(
    .PORT_BITS(PORT_BITS)
) u_btlpm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .found(found),
    .route_port(route_port),
    .nodes_visited(nodes_visited),
    .table_full(table_full)
);

/* tb/sv/route_table_scoreboard_pkg.sv */
// Scoreboard for the binary trie longest-prefix-match testbench: a trie predictor
// and a queue of expected replies, one per accepted beat.
// Depends on btlpm_pkg.
package route_table_scoreboard_pkg;

    localparam int NODES = 65536;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int PLEN_W = btlpm_pkg::PLEN_W;
    localparam int VISIT_W = btlpm_pkg::VISIT_W;

    typedef struct packed {
        logic               found;
        logic [PORT_W-1:0]  port;
        logic [VISIT_W-1:0] visited;
        logic               table_full;
    } route_reply_t;

    class route_table_scoreboard;
        bit                 node_marked[NODES];
        bit [PORT_W-1:0]    node_port[NODES];
        bit [1:0][15:0]     node_child[NODES];
        bit [16:0]          nodes_used;
        route_reply_t       pending_replies[$];
        int unsigned        mismatch_count;
        int unsigned        insert_count;
        int unsigned        full_count;
        int unsigned        lookup_count;
        int unsigned        hit_count;

        function new();
            nodes_used = 17'd1;
        endfunction

        function bit grow_route(bit [ADDR_W-1:0] prefix, bit [PLEN_W-1:0] len,
                                bit [PORT_W-1:0] port);
            bit [PLEN_W-1:0] depth;
            bit [15:0]       node;
            bit [15:0]       next;
            bit              dir;
            depth = (len > ADDR_W) ? PLEN_W'(ADDR_W) : len;
            node = '0;
            for (int lvl = 0; lvl < depth; lvl++)
            begin
                dir = prefix[ADDR_W-1-lvl];
                next = node_child[node][dir];
                if (next == 0)
                begin
                    if (nodes_used == NODES)
                        return 1'b1;
                    next = nodes_used[15:0];
                    node_marked[next] = 1'b0;
                    node_port[next] = '0;
                    node_child[next] = '0;
                    nodes_used++;
                    node_child[node][dir] = next;
                end
                node = next;
            end
            node_marked[node] = 1'b1;
            node_port[node] = port;
            return 1'b0;
        endfunction

        function route_reply_t walk_lookup(bit [ADDR_W-1:0] dest);
            route_reply_t reply;
            bit [15:0]    node;
            bit [15:0]    next;
            reply = '0;
            node = '0;
            if (node_marked[0])
            begin
                reply.found = 1'b1;
                reply.port = node_port[0];
            end
            for (int lvl = 0; lvl < ADDR_W; lvl++)
            begin
                next = node_child[node][dest[ADDR_W-1-lvl]];
                if (next == 0)
                    break;
                node = next;
                if (reply.visited != btlpm_pkg::VISIT_MAX)
                    reply.visited++;
                if (node_marked[node])
                begin
                    reply.found = 1'b1;
                    reply.port = node_port[node];
                end
            end
            return reply;
        endfunction

        function void note_request(bit op, bit [ADDR_W-1:0] addr, bit [PLEN_W-1:0] len,
                                   bit [PORT_W-1:0] port);
            route_reply_t reply;
            reply = '0;
            if (op == btlpm_pkg::OP_INSERT)
            begin
                reply.table_full = grow_route(addr, len, port);
                insert_count++;
                if (reply.table_full)
                    full_count++;
            end
            else
            begin
                reply = walk_lookup(addr);
                lookup_count++;
                if (reply.found)
                    hit_count++;
            end
            pending_replies.push_back(reply);
        endfunction

        function void check_reply(logic found, logic [PORT_W-1:0] port,
                                  logic [VISIT_W-1:0] visited, logic table_full);
            route_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d port=%0h visited=%0d full=%0d",
                         $time, found, port, visited, table_full);
                mismatch_count++;
                return;
            end
            want = pending_replies.pop_front();
            if (found !== want.found)
            begin
                $display("%0t: found expected %0d, actual %0d", $time, want.found, found);
                mismatch_count++;
            end
            if (port !== want.port)
            begin
                $display("%0t: route_port expected %0h, actual %0h", $time, want.port, port);
                mismatch_count++;
            end
            if (visited !== want.visited)
            begin
                $display("%0t: nodes_visited expected %0d, actual %0d",
                         $time, want.visited, visited);
                mismatch_count++;
            end
            if (table_full !== want.table_full)
            begin
                $display("%0t: table_full expected %0d, actual %0d",
                         $time, want.table_full, table_full);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage

/* tb/sv/binary_trie_longest_prefix_match_tb.sv */
// Top of the binary trie longest-prefix-match testbench: clock, reset, beat drivers
// for directed, random and long-route stimulus, and the result monitor.
// Depends on btlpm_pkg, route_table_scoreboard_pkg and the block under test.
module binary_trie_longest_prefix_match_tb;

    localparam int NODES = route_table_scoreboard_pkg::NODES;
    localparam int ADDR_W = route_table_scoreboard_pkg::ADDR_W;
    localparam int PORT_W = route_table_scoreboard_pkg::PORT_W;
    localparam int PLEN_W = btlpm_pkg::PLEN_W;
    localparam int VISIT_W = btlpm_pkg::VISIT_W;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BEATS = 1250;
    localparam int FILL_CAP = 250;
    localparam int TAIL_BEATS = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 opcode = 1'b0;
    logic [ADDR_W-1:0]    address = '0;
    logic [PLEN_W-1:0]    prefix_length = '0;
    logic [PORT_W-1:0]    out_port = '0;
    logic                 busy;
    logic                 done;
    logic                 found;
    logic [PORT_W-1:0]    route_port;
    logic [VISIT_W-1:0]   nodes_visited;
    logic                 table_full;

    route_table_scoreboard_pkg::route_table_scoreboard ledger;
    bit [ADDR_W-1:0]       route_prefix[$];
    bit [PLEN_W-1:0]       route_depth[$];
    bit                    gaps_on;
    bit                    start_high;
    int unsigned           cycle_count;

    binary_trie_longest_prefix_match #(
        .NODE_COUNT(NODES),
        .ADDRESS_BITS(ADDR_W),
        .PORT_BITS(PORT_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .address(address),
        .prefix_length(prefix_length),
        .out_port(out_port),
        .done(done),
        .found(found),
        .route_port(route_port),
        .nodes_visited(nodes_visited),
        .table_full(table_full)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_reply(found, route_port, nodes_visited, table_full);
    end

    function automatic bit [ADDR_W-1:0] lead_mask(bit [PLEN_W-1:0] len);
        bit [PLEN_W-1:0] n;
        n = (len > ADDR_W) ? PLEN_W'(ADDR_W) : len;
        return ADDR_W'(64'hFFFF_FFFF_0000_0000 >> n);
    endfunction

    task automatic send_beat(bit op, bit [ADDR_W-1:0] addr, bit [PLEN_W-1:0] len,
                             bit [PORT_W-1:0] port);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        start <= 1'b1;
        start_high = 1'b1;
        opcode <= op;
        address <= addr;
        prefix_length <= len;
        out_port <= port;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_request(op, addr, len, port);
        if (op == btlpm_pkg::OP_INSERT)
        begin
            route_prefix.push_back(addr);
            route_depth.push_back(len);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            start_high = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_insert();
        bit [ADDR_W-1:0]   addr;
        bit [ADDR_W-1:0]   keep;
        bit [PLEN_W-1:0]   len;
        int unsigned       kind;
        int unsigned       pick;
        addr = $urandom;
        len = PLEN_W'($urandom_range(0, 32));
        kind = $urandom_range(0, 9);
        if (kind < 3)
            len = PLEN_W'(32);
        else if (kind == 3)
            len = PLEN_W'($urandom_range(33, 63));
        else if (kind < 7 && route_prefix.size() != 0)
        begin
            pick = $urandom_range(0, route_prefix.size() - 1);
            if (kind == 4)
            begin
                keep = lead_mask(route_depth[pick]);
                addr = (route_prefix[pick] & keep) | (addr & ~keep);
                len = route_depth[pick];
            end
            else
            begin
                keep = lead_mask(PLEN_W'($urandom_range(0, 32)));
                addr = (route_prefix[pick] & keep) | (addr & ~keep);
            end
        end
        send_beat(btlpm_pkg::OP_INSERT, addr, len, PORT_W'($urandom));
    endtask

    task automatic random_lookup();
        bit [ADDR_W-1:0] addr;
        bit [ADDR_W-1:0] keep;
        int unsigned     pick;
        addr = $urandom;
        if (route_prefix.size() != 0 && $urandom_range(0, 9) < 6)
        begin
            pick = $urandom_range(0, route_prefix.size() - 1);
            keep = lead_mask(route_depth[pick]);
            addr = (route_prefix[pick] & keep) | (addr & ~keep);
        end
        send_beat(btlpm_pkg::OP_LOOKUP, addr, PLEN_W'($urandom), PORT_W'($urandom));
    endtask

    task automatic pick_gap_mode(int unsigned n);
        if (n % 40 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        int unsigned n;
        ledger = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0000_0000, 6'd0, 16'h1234);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 16'h00AA);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 16'h0BBB);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0A01_0203, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0A02_0304, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0000_0000, 6'd63, 16'h0000);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 16'h5555);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0A7F_0000, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'h8000_0000, 6'd33, 16'hAAAA);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h8000_0000, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'h0A01_FFFF, 6'd16, 16'h0001);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h0A01_FFFF, 6'd0, 16'h0000);
        send_beat(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0, 16'hFFFF);
        send_beat(btlpm_pkg::OP_LOOKUP, 32'h1234_5678, 6'd0, 16'h0000);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            pick_gap_mode(n);
            if ($urandom_range(0, 1) == 0)
                random_insert();
            else
                random_lookup();
        end

        // Long random routes grow the node pool with deep, mostly new paths.
        n = 0;
        while (ledger.nodes_used != NODES && n < FILL_CAP)
        begin
            pick_gap_mode(n);
            if ($urandom_range(0, 99) < 85)
                send_beat(btlpm_pkg::OP_INSERT, $urandom, PLEN_W'(32), PORT_W'($urandom));
            else
                random_lookup();
            n++;
        end

        for (n = 0; n < TAIL_BEATS; n++)
        begin
            pick_gap_mode(n);
            if ($urandom_range(0, 1) == 0)
                random_insert();
            else
                random_lookup();
        end

        if (start_high)
            start <= 1'b0;
        while (ledger.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d inserts (%0d stopped by a full node pool) and %0d lookups (%0d matched).",
                 ledger.insert_count, ledger.full_count, ledger.lookup_count, ledger.hit_count);
        $display("Node pool use at the end: %0d of %0d nodes.", ledger.nodes_used, NODES);
        if (ledger.mismatch_count == 0 && ledger.pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
